// ===== design/rgbdd_pkg.sv =====
// Shared types and constants for the RGB565 thumbnail dither block.
package rgbdd_pkg;

    localparam int MODE_W  = 2;
    localparam int PIX_W   = 16;
    localparam int COORD_W = 16;
    localparam int DIM_W   = 16;
    localparam int DATA_W  = 8;
    localparam int CFG_IDX_W = 8;

    // Weighted gray sum 30R+59G+11B on 8-bit channels stays below 2^15.
    localparam int LUMA_W = 15;
    localparam int WEIGHT_R = 30;
    localparam int WEIGHT_G = 59;
    localparam int WEIGHT_B = 11;

    // floor(sum/100) < thr  <=>  sum < 100*thr
    localparam logic [LUMA_W-1:0] THR_EVEN_X100 = LUMA_W'(112 * 100);
    localparam logic [LUMA_W-1:0] THR_ODD_X100  = LUMA_W'(144 * 100);

    typedef enum logic [MODE_W-1:0] {
        MODE_PIXEL = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);

endpackage

// ===== design/rgbdd_if.sv =====
// Valid/ready channel interfaces: pixel input, result output, configuration.
interface rgbdd_in_if #(
    parameter int RIDX_W = 10
);
    logic                             valid;
    logic                             ready;
    logic [rgbdd_pkg::MODE_W-1:0]     mode;
    logic [rgbdd_pkg::PIX_W-1:0]      pixel_value;
    logic [rgbdd_pkg::COORD_W-1:0]    src_x;
    logic [rgbdd_pkg::COORD_W-1:0]    src_y;
    logic [RIDX_W-1:0]                read_index;

    modport source(output valid, mode, pixel_value, src_x, src_y, read_index, input ready);
    modport sink(input valid, mode, pixel_value, src_x, src_y, read_index, output ready);
endinterface

interface rgbdd_out_if #(
    parameter int BIT_W = 13
);
    logic                          valid;
    logic                          ready;
    logic                          landed;
    logic                          dark;
    logic [BIT_W-1:0]              bit_address;
    logic [rgbdd_pkg::DATA_W-1:0]  read_data;

    modport source(output valid, landed, dark, bit_address, read_data, input ready);
    modport sink(input valid, landed, dark, bit_address, read_data, output ready);
endinterface

interface rgbdd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rgbdd_pkg::CFG_IDX_W-1:0]  index;
    logic [rgbdd_pkg::DIM_W-1:0]      data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== design/rgbdd_luma.sv =====
// Weighted gray sum of an RGB565 pixel, registered on load.
module rgbdd_luma (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic [rgbdd_pkg::PIX_W-1:0]     i_pix,
    output logic [rgbdd_pkg::LUMA_W-1:0]    o_luma
);

    logic [rgbdd_pkg::LUMA_W-1:0] r_luma;
    logic [rgbdd_pkg::LUMA_W-1:0] chan_r;
    logic [rgbdd_pkg::LUMA_W-1:0] chan_g;
    logic [rgbdd_pkg::LUMA_W-1:0] chan_b;
    logic [rgbdd_pkg::LUMA_W-1:0] n_luma;

    // Channels widened to 8 bits by a left shift
    assign chan_r = rgbdd_pkg::LUMA_W'({i_pix[15:11], 3'b000});
    assign chan_g = rgbdd_pkg::LUMA_W'({i_pix[10:5], 2'b00});
    assign chan_b = rgbdd_pkg::LUMA_W'({i_pix[4:0], 3'b000});

    assign n_luma = chan_r * rgbdd_pkg::LUMA_W'(rgbdd_pkg::WEIGHT_R)
                  + chan_g * rgbdd_pkg::LUMA_W'(rgbdd_pkg::WEIGHT_G)
                  + chan_b * rgbdd_pkg::LUMA_W'(rgbdd_pkg::WEIGHT_B);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_luma <= n_luma;
        end
    end

    assign o_luma = r_luma;

endmodule

// ===== design/rgbdd_div.sv =====
// Restoring divider, one quotient bit per cycle; quotient known to fit in QW bits.
module rgbdd_div #(
    parameter int QW = 7
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [rgbdd_pkg::DIM_W+QW-1:0]        i_num,
    input  logic [rgbdd_pkg::DIM_W-1:0]           i_den,
    output logic                                  o_done,
    output logic [QW-1:0]                         o_quot
);

    localparam int CNT_W = $clog2(QW + 1);
    localparam int DW    = rgbdd_pkg::DIM_W;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [QW-1:0]    r_low;

    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_sub;
    logic             ge;

    // Shift in the next numerator bit, subtract when it fits
    assign rem_sh  = {r_rem, r_low[QW-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done rises with the last quotient bit, unless a restart comes in
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // numerator < den * 2^QW, so the upper part starts below den
            r_rem <= i_num[DW+QW-1:QW];
            r_low <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_low <= {r_low[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

// ===== design/rgb565_downscale_dither_1bpp_core.sv =====
// Top level: RGB565 to 1 bpp dithered thumbnail with nearest-neighbour mapping.
// Landed pixel: SETUP, two divisions (x in DIVX, y in DIVY) on the shared
//   one-bit-per-cycle divider, QW = clog2(max dim), then ADDR, READ, MODIFY, DONE.
// Read item: SETUP, READ, MODIFY, DONE; off-thumbnail pixel, read past end, unused mode: SETUP, DONE.
// Clear item: SETUP, a CLEAR sweep over all BYTES, DONE. Reset (synchronous): sizes
//   go to 1, then a clearing pass zeroes the bitmap; no item accepted.
module rgb565_downscale_dither_1bpp_core #(
    parameter int THUMB_W = 60,
    parameter int THUMB_H = 80
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rgbdd_in_if.sink          i_in,
    rgbdd_out_if.source       o_out,
    rgbdd_cfg_if.sink         i_cfg
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int BITS    = THUMB_W * THUMB_H;
    localparam int BYTES   = (BITS + 7) / 8;
    localparam int BIT_W   = $clog2(BITS);
    localparam int RIDX_W  = $clog2(BYTES);
    localparam int MAXDIM  = (THUMB_W > THUMB_H) ? THUMB_W : THUMB_H;
    localparam int QW      = $clog2(MAXDIM);
    localparam int DX_W    = $clog2(THUMB_W);
    localparam int DY_W    = $clog2(THUMB_H);
    localparam int DW      = rgbdd_pkg::DIM_W;
    localparam int NUM_W   = DW + QW;
    localparam int DATA_W  = rgbdd_pkg::DATA_W;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_SETUP  = 9'b000000100,
        S_DIVX   = 9'b000001000,
        S_DIVY   = 9'b000010000,
        S_ADDR   = 9'b000100000,
        S_READ   = 9'b001000000,
        S_MODIFY = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state;

    // Configuration
    logic [DW-1:0] r_src_w;
    logic [DW-1:0] r_src_h;

    // Latched item
    rgbdd_pkg::t_mode             r_mode;
    logic [rgbdd_pkg::COORD_W-1:0] r_sx;
    logic [rgbdd_pkg::COORD_W-1:0] r_sy;
    logic [RIDX_W-1:0]            r_ridx;

    // Working results
    logic [DX_W-1:0]   r_dx;
    logic [DY_W-1:0]   r_dy;
    logic              r_landed;
    logic              r_dark;
    logic [BIT_W-1:0]  r_bit;
    logic [DATA_W-1:0] r_rdata;
    logic              r_clr_reply;
    logic [RIDX_W-1:0] r_clr_cnt;

    // Output register
    logic              r_out_valid;
    logic              r_out_landed;
    logic              r_out_dark;
    logic [BIT_W-1:0]  r_out_bit;
    logic [DATA_W-1:0] r_out_rdata;

    // Bitmap store
    logic [DATA_W-1:0] r_mem [BYTES];
    logic [DATA_W-1:0] r_mem_q;
    logic              mem_we;
    logic [RIDX_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [RIDX_W-1:0] mem_raddr;
    logic [DATA_W-1:0] bit_mask;

    // Shared divider hookup
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DW-1:0]     div_den;
    logic              div_done;
    logic [QW-1:0]     div_quot;

    logic [rgbdd_pkg::LUMA_W-1:0] luma;
    logic [rgbdd_pkg::LUMA_W-1:0] thr;
    logic              in_accept;
    logic              out_load;
    logic              ridx_ok;
    logic [BIT_W-1:0]  n_bit;

    assign in_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration writes; indexes past the list are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= DW'(1);
            r_src_h <= DW'(1);
        end else if (i_cfg.valid) begin
            if (i_cfg.index == rgbdd_pkg::REG_SOURCE_WIDTH) begin
                r_src_w <= i_cfg.data;
            end
            if (i_cfg.index == rgbdd_pkg::REG_SOURCE_HEIGHT) begin
                r_src_h <= i_cfg.data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Gray sum, captured with the item
    // ------------------------------------------------------------------
    rgbdd_luma u_luma (
        .i_clk  (i_clk),
        .i_load (in_accept),
        .i_pix  (i_in.pixel_value),
        .o_luma (luma)
    );

    // ------------------------------------------------------------------
    // Divider: x in SETUP, y chained off the x done pulse.
    // A zero size never gets here (src >= 0 fails the range check).
    // ------------------------------------------------------------------
    assign div_start = (r_state == S_SETUP && r_mode == rgbdd_pkg::MODE_PIXEL &&
                        r_sx < r_src_w && r_sy < r_src_h) ||
                       (r_state == S_DIVX && div_done);
    assign div_num = (r_state == S_SETUP) ? NUM_W'(r_sx) * NUM_W'(THUMB_W)
                                          : NUM_W'(r_sy) * NUM_W'(THUMB_H);
    assign div_den = (r_state == S_SETUP) ? r_src_w : r_src_h;

    rgbdd_div #(
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Checkerboard threshold, pre-scaled by 100
    assign thr   = (r_dx[0] ^ r_dy[0]) ? rgbdd_pkg::THR_ODD_X100 : rgbdd_pkg::THR_EVEN_X100;
    assign n_bit = BIT_W'(r_dy) * BIT_W'(THUMB_W) + BIT_W'(r_dx);
    assign ridx_ok = (RIDX_W + 1)'(r_ridx) < (RIDX_W + 1)'(BYTES);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_reply <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (r_clr_cnt == RIDX_W'(BYTES - 1)) begin
                        r_clr_cnt <= '0;
                        r_state   <= r_clr_reply ? S_DONE : S_IDLE;
                    end else begin
                        r_clr_cnt <= r_clr_cnt + RIDX_W'(1);
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    // a clear item answers once its sweep is done
                    r_clr_reply <= (r_mode == rgbdd_pkg::MODE_CLEAR);
                    case (r_mode)
                        rgbdd_pkg::MODE_PIXEL: begin
                            r_state <= div_start ? S_DIVX : S_DONE;
                        end
                        rgbdd_pkg::MODE_READ: begin
                            r_state <= ridx_ok ? S_READ : S_DONE;
                        end
                        rgbdd_pkg::MODE_CLEAR: begin
                            r_state <= S_CLEAR;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_DIVX: begin
                    if (div_done) begin
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (div_done) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR:   r_state <= S_READ;
                S_READ:   r_state <= S_MODIFY;
                S_MODIFY: r_state <= S_DONE;
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload of the item and its working results
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= rgbdd_pkg::t_mode'(i_in.mode);
            r_sx   <= i_in.src_x;
            r_sy   <= i_in.src_y;
            r_ridx <= i_in.read_index;
        end
        case (r_state)
            S_SETUP: begin
                r_landed <= 1'b0;
                r_dark   <= 1'b0;
                r_bit    <= '0;
                r_rdata  <= '0;
            end
            S_DIVX: begin
                if (div_done) begin
                    r_dx <= div_quot[DX_W-1:0];
                end
            end
            S_DIVY: begin
                if (div_done) begin
                    r_dy <= div_quot[DY_W-1:0];
                end
            end
            S_ADDR: begin
                r_landed <= 1'b1;
                r_bit    <= n_bit;
                r_dark   <= luma < thr;
            end
            S_MODIFY: begin
                if (r_mode == rgbdd_pkg::MODE_READ) begin
                    r_rdata <= r_mem_q;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Bitmap store: one write and one registered read port
    // ------------------------------------------------------------------
    assign bit_mask  = DATA_W'(8'h80) >> r_bit[2:0];
    assign mem_we    = (r_state == S_CLEAR) ||
                       (r_state == S_MODIFY && r_mode == rgbdd_pkg::MODE_PIXEL && r_dark);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_cnt : r_bit[3 +: RIDX_W];
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : (r_mem_q | bit_mask);
    assign mem_re    = (r_state == S_READ);
    assign mem_raddr = (r_mode == rgbdd_pkg::MODE_PIXEL) ? r_bit[3 +: RIDX_W] : r_ridx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a finished item while the sink stalls
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_landed <= r_landed;
            r_out_dark   <= r_dark;
            r_out_bit    <= r_bit;
            r_out_rdata  <= r_rdata;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.landed      = r_out_landed;
    assign o_out.dark        = r_out_dark;
    assign o_out.bit_address = r_out_bit;
    assign o_out.read_data   = r_out_rdata;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVX || r_state == S_DIVY))
        else $error("divider finished outside a division state");

    a_dark_needs_landed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.dark) |-> o_out.landed)
        else $error("dark result for a pixel that did not land");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.landed) |->
            ((BIT_W + 1)'(o_out.bit_address) < (BIT_W + 1)'(BITS)))
        else $error("bit address beyond thumbnail");

    a_read_excludes_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.read_data != '0) |-> !o_out.landed)
        else $error("read data and landed pixel in one result");

endmodule
